FILE: rtl/rrsd_pkg.sv
// Shared constants and the colour widening function of the RLE RGB555 sprite decoder.
`default_nettype none

package rrsd_pkg;

  // Fixed field widths.
  localparam int BYTE_W      = 8;
  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 14;
  localparam int BASE_W      = 26;
  localparam int LEN_W       = 24;
  localparam int COLOR_W     = 32;
  localparam int OUT_ADDR_W  = 26;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 3'd6;

  // Stream parser phases.
  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  // Control byte that introduces a skip count.
  localparam logic [BYTE_W-1:0] CTRL_SKIP = 8'hFF;

  // Reset value of the transparent key.
  localparam logic [COLOR_W-1:0] KEY_RESET = 32'hFFF7_00FF;

  // RGB555 to opaque ARGB8888, top bits of each channel replicated into the low bits.
  function automatic logic [COLOR_W-1:0] widen555(input logic [15:0] w);
    return {8'hFF, w[14:10], w[14:12], w[9:5], w[9:7], w[4:0], w[4:2]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rrsd_wrap_unit.sv
// Shared column wrap step: compares the column accumulator with the width and advances the row.
`default_nettype none

module rrsd_wrap_unit #(
  parameter int ACC_W = 14,
  parameter int CW    = 13,
  parameter int AW    = 26
) (
  input  wire logic [ACC_W-1:0]              acc,
  input  wire logic [rrsd_pkg::DIM_W-1:0]    eff_width,
  input  wire logic [CW-1:0]                 row,
  input  wire logic [AW-1:0]                 row_addr,
  input  wire logic [rrsd_pkg::STRIDE_W-1:0] stride,
  output logic                               wrap,
  output logic [ACC_W-1:0]                   acc_sub,
  output logic [CW-1:0]                      row_inc,
  output logic [AW-1:0]                      row_addr_inc
);

  logic [ACC_W-1:0] width_ext;

  assign width_ext    = ACC_W'(eff_width);
  assign wrap         = (acc >= width_ext);
  assign acc_sub      = acc - width_ext;
  assign row_inc      = row + CW'(1);
  assign row_addr_inc = row_addr + AW'(stride);

endmodule

`default_nettype wire

FILE: rtl/rle_rgb555_sprite_decoder.sv
// Top level of the RLE RGB555 sprite decoder: stream parser, position sequencer, result register.
//
//   channel  | ports                                | payload
//   ---------+--------------------------------------+---------------------------------------
//   input    | in_tvalid, in_tready, in_tdata       | data_byte
//   result   | out_tvalid, out_tready, out_tdata,   | tdata: write_address, write_color
//            | out_tuser                            | tuser: write_valid, done_res
//   config   | cfg_valid, cfg_ready, cfg_index,     | register index, write data
//            | cfg_data                             |
//
// After an item is accepted, the wrap step runs once, plus once more for each row that the item
// crosses: a pixel at the end of its row crosses one, and a skip count crosses up to 255 rows
// with a one-pixel width. The wrap step is a single subtract-and-compare unit that the sequencer
// reuses every cycle. The input is ready only between items.
// A result waits in the output register while out_tready is low, which holds the sequencer.
// Reset is synchronous and active low; it loads the register defaults and restarts the sprite.
`default_nettype none

module rle_rgb555_sprite_decoder #(
  parameter int COORD_BITS = 12,
  parameter int ADDR_BITS  = 26
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream. tdata: [7:0] data_byte.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [rrsd_pkg::BYTE_W-1:0]         in_tdata,
  // Result stream. tdata: [25:0] write_address, [57:26] write_color, [63:58] zero.
  // tuser: [0] write_valid, [1] done_res.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [rrsd_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic [rrsd_pkg::OUT_USER_W-1:0]          out_tuser,
  // Configuration writes.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rrsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rrsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Column and row counters carry one bit above the coordinate range.
  localparam int CW    = COORD_BITS + 1;
  localparam int CMPW  = (CW > rrsd_pkg::DIM_W) ? CW : rrsd_pkg::DIM_W;
  localparam int ACC_W = CMPW + 1;
  localparam int AW    = ADDR_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WRAP = 1'b1;

  // Configuration registers.
  logic                            mode_r, mode_nxt;
  logic [rrsd_pkg::DIM_W-1:0]      width_r, width_nxt;
  logic [rrsd_pkg::DIM_W-1:0]      height_r, height_nxt;
  logic [rrsd_pkg::STRIDE_W-1:0]   stride_r, stride_nxt;
  logic [rrsd_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic [rrsd_pkg::LEN_W-1:0]      length_r, length_nxt;
  logic [rrsd_pkg::COLOR_W-1:0]    key_r, key_nxt;

  // Decoder state.
  logic                            state_r, state_nxt;
  logic [1:0]                      phase_r, phase_nxt;
  logic [rrsd_pkg::BYTE_W-1:0]     run_left_r, run_left_nxt;
  logic [rrsd_pkg::BYTE_W-1:0]     low_half_r, low_half_nxt;
  logic [CW-1:0]                   column_r, column_nxt;
  logic [CW-1:0]                   row_r, row_nxt;
  logic [AW-1:0]                   row_addr_r, row_addr_nxt;
  logic [rrsd_pkg::LEN_W-1:0]      bytes_left_r, bytes_left_nxt;
  logic                            finished_r, finished_nxt;
  logic [ACC_W-1:0]                acc_r, acc_nxt;

  // Pixel write decided at acceptance, sent once the position has settled.
  logic                            pend_wv_r, pend_wv_nxt;
  logic [rrsd_pkg::OUT_ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [rrsd_pkg::COLOR_W-1:0]    pend_color_r, pend_color_nxt;

  // Result register.
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_wv_r, out_wv_nxt;
  logic                            out_done_r, out_done_nxt;
  logic [rrsd_pkg::OUT_ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [rrsd_pkg::COLOR_W-1:0]    out_color_r, out_color_nxt;

  logic                            in_fire;
  logic                            cfg_fire;
  logic                            out_free;
  logic                            restart;
  logic [rrsd_pkg::DIM_W-1:0]      eff_width;
  logic                            row_at_end;
  logic                            pre_end;
  logic [rrsd_pkg::COLOR_W-1:0]    pixel_color;
  logic [rrsd_pkg::OUT_ADDR_W-1:0] pixel_addr;
  logic [ACC_W-1:0]                col_plus_one;
  logic [ACC_W-1:0]                col_plus_skip;
  logic                            wrap;
  logic [ACC_W-1:0]                acc_sub;
  logic [CW-1:0]                   row_inc;
  logic [AW-1:0]                   row_addr_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rrsd_pkg::OUT_DATA_W - rrsd_pkg::COLOR_W - rrsd_pkg::OUT_ADDR_W){1'b0}},
                       out_color_r, out_addr_r};
  assign out_tuser  = {out_done_r, out_wv_r};

  // A width of zero behaves as a width of one.
  assign eff_width  = (width_r == '0) ? rrsd_pkg::DIM_W'(1) : width_r;
  assign row_at_end = (CMPW'(row_r) >= CMPW'(height_r));

  // Decoding is over once the image is full or, in compressed mode, the budget is spent at a
  // record boundary. The same test runs before an item and again after its position settles.
  assign pre_end = finished_r || row_at_end ||
                   (mode_r && (phase_r == rrsd_pkg::PH_CTRL) && (bytes_left_r == '0));

  assign pixel_color   = rrsd_pkg::widen555({in_tdata, low_half_r});
  assign pixel_addr    = rrsd_pkg::OUT_ADDR_W'(row_addr_r + AW'(column_r));
  assign col_plus_one  = ACC_W'(CW'(column_r + CW'(1)));
  assign col_plus_skip = ACC_W'(column_r) + ACC_W'(in_tdata);

  rrsd_wrap_unit #(
    .ACC_W (ACC_W),
    .CW    (CW),
    .AW    (AW)
  ) u_wrap (
    .acc          (acc_r),
    .eff_width    (eff_width),
    .row          (row_r),
    .row_addr     (row_addr_r),
    .stride       (stride_r),
    .wrap         (wrap),
    .acc_sub      (acc_sub),
    .row_inc      (row_inc),
    .row_addr_inc (row_addr_inc)
  );

  always_comb begin
    mode_nxt       = mode_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    stride_nxt     = stride_r;
    base_nxt       = base_r;
    length_nxt     = length_r;
    key_nxt        = key_r;
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    run_left_nxt   = run_left_r;
    low_half_nxt   = low_half_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    row_addr_nxt   = row_addr_r;
    bytes_left_nxt = bytes_left_r;
    finished_nxt   = finished_r;
    acc_nxt        = acc_r;
    pend_wv_nxt    = pend_wv_r;
    pend_addr_nxt  = pend_addr_r;
    pend_color_nxt = pend_color_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_wv_nxt     = out_wv_r;
    out_done_nxt   = out_done_r;
    out_addr_nxt   = out_addr_r;
    out_color_nxt  = out_color_r;
    restart        = 1'b0;

    if (cfg_fire) begin
      restart = 1'b1;
      case (cfg_index)
        rrsd_pkg::REG_MODE:   mode_nxt   = cfg_data[0];
        rrsd_pkg::REG_WIDTH:  width_nxt  = cfg_data[rrsd_pkg::DIM_W-1:0];
        rrsd_pkg::REG_HEIGHT: height_nxt = cfg_data[rrsd_pkg::DIM_W-1:0];
        rrsd_pkg::REG_STRIDE: stride_nxt = cfg_data[rrsd_pkg::STRIDE_W-1:0];
        rrsd_pkg::REG_BASE:   base_nxt   = cfg_data[rrsd_pkg::BASE_W-1:0];
        rrsd_pkg::REG_LENGTH: length_nxt = cfg_data[rrsd_pkg::LEN_W-1:0];
        rrsd_pkg::REG_KEY:    key_nxt    = cfg_data;
        default:              restart    = 1'b0;
      endcase
      // Any write to a defined register (index 0 to 6) starts the sprite over with the new settings.
      if (restart) begin
        state_nxt      = ST_IDLE;
        phase_nxt      = rrsd_pkg::PH_CTRL;
        run_left_nxt   = '0;
        low_half_nxt   = '0;
        column_nxt     = '0;
        row_nxt        = '0;
        row_addr_nxt   = AW'(base_nxt);
        bytes_left_nxt = length_nxt;
        finished_nxt   = 1'b0;
      end
    end else if (state_r == ST_IDLE) begin
      if (in_fire) begin
        state_nxt      = ST_WRAP;
        acc_nxt        = ACC_W'(column_r);
        pend_wv_nxt    = 1'b0;
        pend_addr_nxt  = '0;
        pend_color_nxt = '0;
        if (pre_end) begin
          // Bytes after the end are swallowed.
          finished_nxt = 1'b1;
        end else if (!mode_r) begin
          // Raw mode: pairs of bytes, keyed colour becomes transparent.
          if (phase_r != rrsd_pkg::PH_HIGH) begin
            low_half_nxt = in_tdata;
            phase_nxt    = rrsd_pkg::PH_HIGH;
          end else begin
            pend_wv_nxt    = 1'b1;
            pend_addr_nxt  = pixel_addr;
            pend_color_nxt = (pixel_color == key_r) ? '0 : pixel_color;
            phase_nxt      = rrsd_pkg::PH_LOW;
            acc_nxt        = col_plus_one;
          end
        end else begin
          if (bytes_left_r != '0) begin
            bytes_left_nxt = bytes_left_r - rrsd_pkg::LEN_W'(1);
          end
          case (phase_r)
            rrsd_pkg::PH_CTRL: begin
              if (in_tdata == rrsd_pkg::CTRL_SKIP) begin
                phase_nxt = rrsd_pkg::PH_SKIP;
              end else if (in_tdata != '0) begin
                run_left_nxt = in_tdata;
                phase_nxt    = rrsd_pkg::PH_LOW;
              end
            end
            rrsd_pkg::PH_SKIP: begin
              // The wrap step then peels off whole rows one per cycle.
              acc_nxt   = col_plus_skip;
              phase_nxt = rrsd_pkg::PH_CTRL;
            end
            rrsd_pkg::PH_LOW: begin
              low_half_nxt = in_tdata;
              phase_nxt    = rrsd_pkg::PH_HIGH;
            end
            default: begin
              // Literal pixels are never keyed.
              pend_wv_nxt    = 1'b1;
              pend_addr_nxt  = pixel_addr;
              pend_color_nxt = pixel_color;
              acc_nxt        = col_plus_one;
              if (run_left_r <= rrsd_pkg::BYTE_W'(1)) begin
                run_left_nxt = '0;
                phase_nxt    = rrsd_pkg::PH_CTRL;
              end else begin
                run_left_nxt = run_left_r - rrsd_pkg::BYTE_W'(1);
                phase_nxt    = rrsd_pkg::PH_LOW;
              end
            end
          endcase
        end
      end
    end else begin
      if (wrap) begin
        acc_nxt      = acc_sub;
        row_nxt      = row_inc;
        row_addr_nxt = row_addr_inc;
      end else if (out_free) begin
        // Position has settled: close the item and present its result.
        column_nxt    = CW'(acc_r);
        finished_nxt  = pre_end;
        out_valid_nxt = 1'b1;
        out_wv_nxt    = pend_wv_r;
        out_addr_nxt  = pend_addr_r;
        out_color_nxt = pend_color_r;
        out_done_nxt  = pre_end;
        state_nxt     = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      width_r      <= rrsd_pkg::DIM_W'(1);
      height_r     <= rrsd_pkg::DIM_W'(1);
      stride_r     <= rrsd_pkg::STRIDE_W'(1);
      base_r       <= '0;
      length_r     <= '0;
      key_r        <= rrsd_pkg::KEY_RESET;
      state_r      <= ST_IDLE;
      phase_r      <= rrsd_pkg::PH_CTRL;
      run_left_r   <= '0;
      low_half_r   <= '0;
      column_r     <= '0;
      row_r        <= '0;
      row_addr_r   <= '0;
      bytes_left_r <= '0;
      finished_r   <= 1'b0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      stride_r     <= stride_nxt;
      base_r       <= base_nxt;
      length_r     <= length_nxt;
      key_r        <= key_nxt;
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      run_left_r   <= run_left_nxt;
      low_half_r   <= low_half_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      row_addr_r   <= row_addr_nxt;
      bytes_left_r <= bytes_left_nxt;
      finished_r   <= finished_nxt;
      acc_r        <= acc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_wv_r    <= pend_wv_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_color_r <= pend_color_nxt;
    out_wv_r     <= out_wv_nxt;
    out_done_r   <= out_done_nxt;
    out_addr_r   <= out_addr_nxt;
    out_color_r  <= out_color_nxt;
  end

  // A result without a pixel write carries an all-zero payload.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wv_r) |-> (out_addr_r == '0 && out_color_r == '0))
    else $error("result without a write has a nonzero payload");

  // Between items the column always lies inside the row.
  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (ACC_W'(column_r) < ACC_W'(eff_width)))
    else $error("column left outside the image width");

  // Only a configuration write brings a finished sprite back to life.
  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r && !cfg_fire) |=> finished_r)
    else $error("finished flag cleared without a register write");

  // Leaving the wrap sequencer always presents a result.
  a_wrap_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRAP && !wrap && out_free && !cfg_fire) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("item closed without a result");

endmodule

`default_nettype wire
